// File: design/pose_keyframe_waypoint_recorder_unit_defines.svh
// ----------------------------------------------------------------------------
// pose keyframe waypoint recorder assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef POSE_KEYFRAME_WAYPOINT_RECORDER_UNIT_DEFINES_SVH
`define POSE_KEYFRAME_WAYPOINT_RECORDER_UNIT_DEFINES_SVH

// same-cycle implication
`define PKWR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PKWR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pkwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwr_pkg
// types, widths, register map and status codes of the waypoint recorder
// ----------------------------------------------------------------------------
package pkwr_pkg;

    localparam int POS_W     = 32;
    localparam int HEAD_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int ID_W      = 7;
    localparam int DIST_W    = 24;
    localparam int ANGLE_W   = 15;
    localparam int SQ_W      = 64;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [DIST_W-1:0]  DIST_STEP_RST   = 24'd131072;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 15'd6434;
    localparam logic [DIST_W-1:0]  NEAR_RADIUS_RST = 24'd32768;
    localparam logic [ID_W-1:0]    NEXT_ID_RST     = 7'd1;

    // register index, taken from paddr[3:2]
    localparam logic [REG_IDX_W-1:0] REG_DIST_STEP   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NEAR_RADIUS = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_REF       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_ACTION = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_CREATED   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_CLOSE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

// File: design/pkwr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwr_if
// valid/ready channels for pose items and result items
// ----------------------------------------------------------------------------
interface pkwr_pose_if import pkwr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;

    modport source (output valid, command, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, command, pos_x, pos_y, heading, output ready);
endinterface

interface pkwr_result_if import pkwr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     point_id;
    logic                manual_kind;

    modport source (output valid, status, point_id, manual_kind, input ready);
    modport sink   (input valid, status, point_id, manual_kind, output ready);
endinterface

// File: design/pose_keyframe_waypoint_recorder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_keyframe_waypoint_recorder_unit
// keyframe detection and waypoint table over a rotating chain of cells
// ----------------------------------------------------------------------------
// One pose is handled at a time, from transfer to result. The stored
// waypoints sit in a ring of cells that rotates once per pose past a single
// pipelined squared distance unit, which also squares the two thresholds and
// measures the move from the reference. A new pose is taken while the previous
// result still waits at the output register. Configuration writes land at
// paddr 0, 4 and 8 and are meant to happen while idle.
// ----------------------------------------------------------------------------
module pose_keyframe_waypoint_recorder_unit import pkwr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pkwr_pose_if.sink            i_pose,
    pkwr_result_if.source        o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

`include "pose_keyframe_waypoint_recorder_unit_defines.svh"

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LAST  = TABLE_DEPTH + 2;
    localparam int ISS_W = $clog2(TABLE_DEPTH + 4);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [ISS_W-1:0] SLOT_S2 = ISS_W'(0);
    localparam logic [ISS_W-1:0] SLOT_R2 = ISS_W'(1);
    localparam logic [ISS_W-1:0] SLOT_D2 = ISS_W'(2);
    localparam logic [ISS_W-1:0] SLOT_T0 = ISS_W'(3);

    logic [1:0]          r_state;
    logic                r_cmd;
    t_pos                r_x;
    t_pos                r_y;
    logic signed [HEAD_W-1:0] r_h;

    logic [DIST_W-1:0]   r_dist_step;
    logic [ANGLE_W-1:0]  r_angle_step;
    logic [DIST_W-1:0]   r_near_radius;

    logic                r_have_ref;
    t_pos                r_ref_x;
    t_pos                r_ref_y;
    logic signed [HEAD_W-1:0] r_ref_h;
    logic [CNT_W-1:0]    r_count;
    logic [ID_W-1:0]     r_next_id;

    logic [ISS_W-1:0]    r_issue;
    logic [SQ_W-1:0]     r_s2;
    logic [SQ_W-1:0]     r_r2;
    logic                r_d2_ge;
    logic                r_near;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_kind;

    // chain
    t_pos       w_cell_x [TABLE_DEPTH];
    t_pos       w_cell_y [TABLE_DEPTH];
    t_cell_ctrl w_ctrl   [TABLE_DEPTH];

    // distance unit
    logic             w_iss_valid;
    t_pos             w_ax;
    t_pos             w_ay;
    t_pos             w_bx;
    t_pos             w_by;
    logic             w_res_valid;
    logic [ISS_W-1:0] w_res_tag;
    logic [SQ_W-1:0]  w_res_sum;

    // decision
    logic                   w_accept;
    logic                   w_cfg_wr;
    logic                   w_out_free;
    logic signed [HEAD_W:0] w_dh;
    logic [HEAD_W:0]        w_adh;
    logic                   w_key;
    logic                   w_try;
    logic                   w_store;
    logic                   w_move_ref;
    logic [STATUS_W-1:0]    w_status;

    // apb
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_DIST_STEP:   prdata = PDATA_W'(r_dist_step);
            REG_ANGLE_STEP:  prdata = PDATA_W'(r_angle_step);
            REG_NEAR_RADIUS: prdata = PDATA_W'(r_near_radius);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_step   <= DIST_STEP_RST;
            r_angle_step  <= ANGLE_STEP_RST;
            r_near_radius <= NEAR_RADIUS_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_DIST_STEP:   r_dist_step   <= pwdata[DIST_W-1:0];
                REG_ANGLE_STEP:  r_angle_step  <= pwdata[ANGLE_W-1:0];
                REG_NEAR_RADIUS: r_near_radius <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign i_pose.ready = (r_state == ST_IDLE);
    assign w_accept     = i_pose.valid && i_pose.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.point_id    = r_out_id;
    assign o_result.manual_kind = r_out_kind;

    // operand selection per slot
    assign w_iss_valid = (r_state == ST_RUN) && (r_issue <= ISS_W'(LAST));

    always_comb begin
        w_ax = r_x;
        w_ay = r_y;
        w_bx = w_cell_x[0];
        w_by = w_cell_y[0];
        if (r_issue == SLOT_S2) begin
            w_ax = POS_W'(r_dist_step);
            w_ay = '0;
            w_bx = '0;
            w_by = '0;
        end else if (r_issue == SLOT_R2) begin
            w_ax = POS_W'(r_near_radius);
            w_ay = '0;
            w_bx = '0;
            w_by = '0;
        end else if (r_issue == SLOT_D2) begin
            w_bx = r_ref_x;
            w_by = r_ref_y;
        end
    end

    pkwr_dist_unit #(
        .TAG_W (ISS_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_iss_valid),
        .i_tag   (r_issue),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .o_valid (w_res_valid),
        .o_tag   (w_res_tag),
        .o_sum   (w_res_sum)
    );

    // decision
    assign w_dh  = {r_h[HEAD_W-1], r_h} - {r_ref_h[HEAD_W-1], r_ref_h};
    assign w_adh = w_dh[HEAD_W] ? (HEAD_W+1)'(-w_dh) : w_dh;
    assign w_key = r_d2_ge || (w_adh >= (HEAD_W+1)'(r_angle_step));
    assign w_try = r_cmd || (r_have_ref && w_key);
    assign w_move_ref = !r_cmd && r_have_ref && w_key;

    always_comb begin
        w_store = 1'b0;
        if (!r_cmd && !r_have_ref) begin
            w_status = STAT_REF;
        end else if (w_try) begin
            if (r_near) begin
                w_status = STAT_TOO_CLOSE;
            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                w_status = STAT_FULL;
            end else begin
                w_status = STAT_CREATED;
                w_store  = 1'b1;
            end
        end else begin
            w_status = STAT_NO_ACTION;
        end
    end

    // ring of cells, rotating toward cell 0
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        assign w_ctrl[k].shift = w_iss_valid && (r_issue >= SLOT_T0);
        assign w_ctrl[k].load  = (r_state == ST_DONE) && w_out_free && w_store
                                 && (r_count == CNT_W'(k));
        pkwr_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl[k]),
            .i_next_x (w_cell_x[(k + 1) % TABLE_DEPTH]),
            .i_next_y (w_cell_y[(k + 1) % TABLE_DEPTH]),
            .i_load_x (r_x),
            .i_load_y (r_y),
            .o_x      (w_cell_x[k]),
            .o_y      (w_cell_y[k])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_ref  <= 1'b0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_ref_h     <= '0;
            r_count     <= '0;
            r_next_id   <= NEXT_ID_RST;
            r_issue     <= '0;
            r_d2_ge     <= 1'b0;
            r_near      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_issue <= '0;
                        r_d2_ge <= 1'b0;
                        r_near  <= 1'b0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_iss_valid) begin
                        r_issue <= r_issue + ISS_W'(1);
                    end
                    if (w_res_valid) begin
                        if (w_res_tag == SLOT_D2) begin
                            r_d2_ge <= (w_res_sum >= r_s2);
                        end else if (w_res_tag >= SLOT_T0) begin
                            if (((w_res_tag - SLOT_T0) < ISS_W'(r_count))
                                && (w_res_sum < r_r2)) begin
                                r_near <= 1'b1;
                            end
                        end
                        if (w_res_tag == ISS_W'(LAST)) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (w_store) begin
                            r_count   <= r_count + CNT_W'(1);
                            r_next_id <= r_next_id + ID_W'(1);
                        end
                        if (!r_cmd && !r_have_ref) begin
                            r_have_ref <= 1'b1;
                        end
                        if ((!r_cmd && !r_have_ref) || w_move_ref) begin
                            r_ref_x <= r_x;
                            r_ref_y <= r_y;
                            r_ref_h <= r_h;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_pose.command;
            r_x   <= i_pose.pos_x;
            r_y   <= i_pose.pos_y;
            r_h   <= i_pose.heading;
        end
        if (w_res_valid && (w_res_tag == SLOT_S2)) begin
            r_s2 <= w_res_sum;
        end
        if (w_res_valid && (w_res_tag == SLOT_R2)) begin
            r_r2 <= w_res_sum;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_status <= w_status;
            r_out_id     <= w_store ? r_next_id : '0;
            r_out_kind   <= w_store && r_cmd;
        end
    end

    `PKWR_ASSERT_IMP(a_out_from_done, $rose(r_out_valid), $past(r_state) == ST_DONE,
        "result raised outside decision state")
    `PKWR_ASSERT_IMP(a_count_with_create, r_count != $past(r_count),
        r_out_valid && (r_out_status == STAT_CREATED), "table grew without a create result")
    `PKWR_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH),
        "table count beyond depth")
    `PKWR_ASSERT_IMP(a_shift_in_run, w_ctrl[0].shift, r_state == ST_RUN,
        "cell ring rotating outside a walk")

endmodule

// File: design/pkwr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwr_cell
// one stored waypoint; loads a new point or takes its neighbor's point
// ----------------------------------------------------------------------------
module pkwr_cell import pkwr_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_pos       i_next_x,
    input  t_pos       i_next_y,
    input  t_pos       i_load_x,
    input  t_pos       i_load_y,
    output t_pos       o_x,
    output t_pos       o_y
);

    t_pos r_x;
    t_pos r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_ctrl.shift) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// File: design/pkwr_dist_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwr_dist_unit
// three-stage squared planar distance with saturated differences
// ----------------------------------------------------------------------------
module pkwr_dist_unit import pkwr_pkg::*; #(
    parameter int TAG_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [TAG_W-1:0] i_tag,
    input  t_pos             i_ax,
    input  t_pos             i_ay,
    input  t_pos             i_bx,
    input  t_pos             i_by,
    output logic             o_valid,
    output logic [TAG_W-1:0] o_tag,
    output logic [SQ_W-1:0]  o_sum
);

    function automatic logic [POS_W-1:0] sat_mag(input t_pos a, input t_pos b);
        logic signed [POS_W:0] d;
        logic signed [POS_W:0] n;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        n = -d;
        if (d > 33'sh0_7FFF_FFFF) begin
            sat_mag = 32'h7FFF_FFFF;
        end else if (d < -33'sh0_8000_0000) begin
            sat_mag = 32'h8000_0000;
        end else if (d < 0) begin
            sat_mag = n[POS_W-1:0];
        end else begin
            sat_mag = d[POS_W-1:0];
        end
    endfunction

    logic [2:0]            r_valid;
    logic [TAG_W-1:0]      r_tag [3];
    logic [POS_W-1:0]      r_mag_x;
    logic [POS_W-1:0]      r_mag_y;
    logic [SQ_W-1:0]       r_sq_x;
    logic [SQ_W-1:0]       r_sq_y;
    logic [SQ_W-1:0]       r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
        r_mag_x  <= sat_mag(i_ax, i_bx);
        r_mag_y  <= sat_mag(i_ay, i_by);
        r_sq_x   <= SQ_W'(r_mag_x) * SQ_W'(r_mag_x);
        r_sq_y   <= SQ_W'(r_mag_y) * SQ_W'(r_mag_y);
        r_sum    <= r_sq_x + r_sq_y;
    end

    assign o_valid = r_valid[2];
    assign o_tag   = r_tag[2];
    assign o_sum   = r_sum;

endmodule
